/* hdl/mrfm_pkg.sv */
`default_nettype none
package mrfm_pkg;
    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_RDG = 1'b1;
    localparam logic FUNC_REQ = 1'b0;
    localparam logic FUNC_RX  = 1'b1;

    localparam logic [7:0] REG_SLAVE_ADDRESS = 8'd0;
    localparam logic [7:0] REG_FUNCTION_CODE = 8'd1;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last_byte;
        logic [2:0]  reading_quantity;
        logic [31:0] reading_value;
        logic        crc_ok;
    } t_result;

    // Classified job handed from front to back.
    typedef struct packed {
        logic        is_reading;
        logic [15:0] reg_addr;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [2:0]  quantity;
        logic [31:0] value;
        logic        crc_ok;
    } t_job;

    function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (x[0]) x = (x >> 1) ^ CRC_POLY;
            else      x = x >> 1;
        end
        return x;
    endfunction

    function automatic logic [15:0] reg_of_quantity(input logic [2:0] q);
        logic [15:0] r;
        unique case (q)
            3'd2:    r = 16'h0006;
            3'd3:    r = 16'h000C;
            3'd4:    r = 16'h0156;
            3'd5:    r = 16'h0180;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/mrfm_if.sv */
`default_nettype none
interface mrfm_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [2:0] quantity;
    logic [7:0] rx_byte;
    modport source (output valid, func, quantity, rx_byte, input ready);
    modport sink   (input valid, func, quantity, rx_byte, output ready);
endinterface

interface mrfm_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [2:0]  reading_quantity;
    logic [31:0] reading_value;
    logic        crc_ok;
    modport source (output valid, kind, tx_byte, last_byte, reading_quantity,
                    reading_value, crc_ok, input ready);
    modport sink   (input valid, kind, tx_byte, last_byte, reading_quantity,
                    reading_value, crc_ok, output ready);
endinterface
`default_nettype wire

/* hdl/mrfm_front.sv */
`default_nettype none
module mrfm_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_func,
    input  wire logic [2:0]        i_quantity,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_slave_address,
    input  wire logic [7:0]        i_function_code,
    output logic                   o_push,
    output mrfm_pkg::t_job         o_job
);
    logic [2:0]  r_pending, n_pending;
    logic [3:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_data [4];
    logic [7:0]  r_crc_low;
    logic [31:0] w_bits;
    logic [15:0] w_got;
    logic        w_ok;
    logic        w_qok;

    function automatic logic [31:0] f2u(input logic [31:0] b);
        logic [7:0]  ex;
        logic [31:0] m;
        logic [31:0] r;
        ex = b[30:23];
        m  = {8'd0, 1'b1, b[22:0]};
        if (ex == 8'hFF) r = (b[22:0] != 23'd0 || !b[31]) ? 32'hFFFF_FFFF : 32'd0;
        else if (b[31] || ex < 8'd127) r = 32'd0;
        else if (ex >= 8'd159) r = 32'hFFFF_FFFF;
        else if (ex >= 8'd150) r = m << (ex - 8'd150);
        else r = m >> (8'd150 - ex);
        return r;
    endfunction

    assign w_bits = {r_data[0], r_data[1], r_data[2], r_data[3]};
    assign w_got  = {i_rx_byte, r_crc_low};
    assign w_ok   = (w_got == r_crc);
    assign w_qok  = (i_quantity >= 3'd1) && (i_quantity <= 3'd5);

    always_comb begin
        n_pending = r_pending;
        n_count   = r_count;
        n_crc     = r_crc;
        o_push    = 1'b0;
        o_job     = '0;
        o_job.slave_address = i_slave_address;
        o_job.function_code = i_function_code;
        o_job.reg_addr      = mrfm_pkg::reg_of_quantity(i_quantity);
        if (i_accept) begin
            if (i_func == mrfm_pkg::FUNC_REQ) begin
                if (w_qok) begin
                    o_push    = 1'b1;
                    n_pending = i_quantity;
                    n_count   = 4'd0;
                    n_crc     = mrfm_pkg::CRC_INIT;
                end
            end else if (r_count < 4'd8) begin
                if (r_count < 4'd7) n_crc = mrfm_pkg::crc_update(r_crc, i_rx_byte);
                n_count = r_count + 4'd1;
            end else begin
                o_push           = 1'b1;
                o_job.is_reading = 1'b1;
                o_job.quantity   = r_pending;
                o_job.crc_ok     = w_ok;
                o_job.value      = w_ok ? f2u(w_bits) : 32'd0;
                n_count          = 4'd0;
                n_crc            = mrfm_pkg::CRC_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
            r_count   <= 4'd0;
            r_crc     <= mrfm_pkg::CRC_INIT;
        end else begin
            r_pending <= n_pending;
            r_count   <= n_count;
            r_crc     <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_func == mrfm_pkg::FUNC_RX) begin
            if (r_count >= 4'd3 && r_count <= 4'd6) r_data[2'(r_count - 4'd3)] <= i_rx_byte;
            if (r_count == 4'd7) r_crc_low <= i_rx_byte;
        end
    end
endmodule
`default_nettype wire

/* hdl/mrfm_queue.sv */
`default_nettype none
module mrfm_queue #(
    parameter int unsigned DEPTH = mrfm_pkg::FIFO_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mrfm_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic                o_full,
    output mrfm_pkg::t_job      o_job
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    mrfm_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

/* hdl/mrfm_back.sv */
`default_nettype none
module mrfm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire mrfm_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mrfm_pkg::t_result   o_res
);
    logic [2:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_valid;
    mrfm_pkg::t_result r_res, w_res;
    logic [7:0]  w_byte;
    logic        w_adv, w_fin;

    always_comb begin
        unique case (r_idx)
            3'd0: w_byte = i_job.slave_address;
            3'd1: w_byte = i_job.function_code;
            3'd2: w_byte = i_job.reg_addr[15:8];
            3'd3: w_byte = i_job.reg_addr[7:0];
            3'd4: w_byte = 8'h00;
            3'd5: w_byte = 8'h02;
            3'd6: w_byte = r_crc[7:0];
            default: w_byte = r_crc[15:8];
        endcase
        w_res = '0;
        if (i_job.is_reading) begin
            w_res.kind             = mrfm_pkg::KIND_RDG;
            w_res.reading_quantity = i_job.quantity;
            w_res.reading_value    = i_job.value;
            w_res.crc_ok           = i_job.crc_ok;
        end else begin
            w_res.kind      = mrfm_pkg::KIND_TX;
            w_res.tx_byte   = w_byte;
            w_res.last_byte = (r_idx == 3'd7);
        end
    end

    // advance when the queue holds a job and the output register is free or being drained
    assign w_adv = !i_empty && (!r_valid || i_ready);
    assign w_fin = i_job.is_reading || (r_idx == 3'd7);
    assign o_pop = w_adv && w_fin;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
            r_crc   <= mrfm_pkg::CRC_INIT;
        end else begin
            if (w_adv) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            if (w_adv && !i_job.is_reading) begin
                r_idx <= w_fin ? 3'd0 : r_idx + 3'd1;
                if (w_fin) r_crc <= mrfm_pkg::CRC_INIT;
                else if (r_idx < 3'd6) r_crc <= mrfm_pkg::crc_update(r_crc, w_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_res <= w_res;
    end
endmodule
`default_nettype wire

/* hdl/modbus_rtu_float_register_master.sv */
`default_nettype none
// Modbus RTU master for one float reading. A request produces eight transmit-byte
// results, one per cycle from the back end while the output is ready, CRC computed
// a byte per cycle; a ninth response byte produces one reading result.
// The job queue (FIFO_DEPTH entries) lets requests and bytes keep arriving while
// frames drain; input ready drops only when that queue is full.
module modbus_rtu_float_register_master #(
    parameter int unsigned FIFO_DEPTH = mrfm_pkg::FIFO_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    mrfm_in_if.sink         s_in,
    mrfm_out_if.source      m_out
);
    logic [7:0] r_slave_address, r_function_code;
    logic w_push, w_pop, w_empty, w_full, w_accept;
    mrfm_pkg::t_job w_job_in, w_job_out;
    mrfm_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 8'd1;
            r_function_code <= 8'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_index == mrfm_pkg::REG_SLAVE_ADDRESS) r_slave_address <= i_cfg_data;
            if (i_cfg_index == mrfm_pkg::REG_FUNCTION_CODE) r_function_code <= i_cfg_data;
        end
    end

    assign s_in.ready = !w_full;
    assign w_accept   = s_in.valid && !w_full;

    mrfm_front u_front (
        .i_clk, .i_rst_n,
        .i_func(s_in.func), .i_quantity(s_in.quantity),
        .i_rx_byte(s_in.rx_byte), .i_accept(w_accept),
        .i_slave_address(r_slave_address), .i_function_code(r_function_code),
        .o_push(w_push), .o_job(w_job_in)
    );

    mrfm_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_job_in), .i_pop(w_pop),
        .o_empty(w_empty), .o_full(w_full), .o_job(w_job_out)
    );

    mrfm_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_job(w_job_out), .o_pop(w_pop),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_res(w_res)
    );

    assign m_out.kind             = w_res.kind;
    assign m_out.tx_byte          = w_res.tx_byte;
    assign m_out.last_byte        = w_res.last_byte;
    assign m_out.reading_quantity = w_res.reading_quantity;
    assign m_out.reading_value    = w_res.reading_value;
    assign m_out.crc_ok           = w_res.crc_ok;
endmodule
`default_nettype wire

/* verif/mrfm_checker.sv */
`default_nettype none
module mrfm_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    mrfm_in_if              in_mon,
    mrfm_out_if             out_mon,
    output int              o_errors,
    output int              o_waiting
);
    logic [7:0]  addr_q;
    logic [7:0]  fcode_q;
    logic [2:0]  quantity_q;
    logic [3:0]  byte_cnt;
    logic [15:0] run_crc;
    logic [7:0]  value_bytes [4];
    logic [7:0]  crc_lo_q;
    mrfm_pkg::t_result expected_results [$];

    assign o_waiting = expected_results.size();

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        return r;
    endfunction

    // Truncate toward zero, clamp negatives to 0 and overflow/inf/NaN to all ones.
    function automatic logic [31:0] float_to_count(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [63:0] m;
        int          e;
        ex = bits[30:23];
        m  = {41'd0, bits[22:0]};
        if (ex == 8'hFF) return (m != 0) ? 32'hFFFF_FFFF : (bits[31] ? 32'd0 : 32'hFFFF_FFFF);
        if (bits[31]) return 32'd0;
        e = int'(ex) - 127;
        if (e < 0) return 32'd0;
        if (e >= 32) return 32'hFFFF_FFFF;
        m = m | 64'h80_0000;
        if (e >= 23) m = m << (e - 23);
        else m = m >> (23 - e);
        return m[31:0];
    endfunction

    function automatic logic [15:0] register_of(input logic [2:0] q);
        case (q)
            3'd2:    return 16'h0006;
            3'd3:    return 16'h000C;
            3'd4:    return 16'h0156;
            3'd5:    return 16'h0180;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic predict(input logic f, input logic [2:0] q, input logic [7:0] b);
        logic [7:0]  frame [8];
        logic [15:0] c;
        logic [15:0] reg_addr;
        mrfm_pkg::t_result r;
        if (f == mrfm_pkg::FUNC_REQ) begin
            if (q < 3'd1 || q > 3'd5) return;
            reg_addr = register_of(q);
            frame[0] = addr_q;
            frame[1] = fcode_q;
            frame[2] = reg_addr[15:8];
            frame[3] = reg_addr[7:0];
            frame[4] = 8'h00;
            frame[5] = 8'h02;
            c = 16'hFFFF;
            for (int k = 0; k < 6; k++) c = crc16_step(c, frame[k]);
            frame[6] = c[7:0];
            frame[7] = c[15:8];
            for (int k = 0; k < 8; k++) begin
                r = '0;
                r.kind = mrfm_pkg::KIND_TX;
                r.tx_byte = frame[k];
                r.last_byte = (k == 7);
                expected_results.push_back(r);
            end
            quantity_q = q;
            byte_cnt = 4'd0;
            run_crc = 16'hFFFF;
            return;
        end
        if (byte_cnt < 4'd7) run_crc = crc16_step(run_crc, b);
        if (byte_cnt >= 4'd3 && byte_cnt <= 4'd6) value_bytes[2'(byte_cnt - 4'd3)] = b;
        if (byte_cnt == 4'd7) crc_lo_q = b;
        if (byte_cnt < 4'd8) begin
            byte_cnt = byte_cnt + 4'd1;
            return;
        end
        r = '0;
        r.kind = mrfm_pkg::KIND_RDG;
        r.reading_quantity = quantity_q;
        r.crc_ok = ({b, crc_lo_q} == run_crc);
        if (r.crc_ok)
            r.reading_value = float_to_count({value_bytes[0], value_bytes[1],
                                              value_bytes[2], value_bytes[3]});
        expected_results.push_back(r);
        byte_cnt = 4'd0;
        run_crc = 16'hFFFF;
    endtask

    task automatic check_result();
        mrfm_pkg::t_result want;
        mrfm_pkg::t_result got;
        got.kind = out_mon.kind;
        got.tx_byte = out_mon.tx_byte;
        got.last_byte = out_mon.last_byte;
        got.reading_quantity = out_mon.reading_quantity;
        got.reading_value = out_mon.reading_value;
        got.crc_ok = out_mon.crc_ok;
        if (expected_results.size() == 0) begin
            o_errors++;
            $display("%0t: unexpected result %p", $time, got);
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind) begin
            o_errors++;
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        end
        if (got.tx_byte !== want.tx_byte) begin
            o_errors++;
            $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, got.tx_byte);
        end
        if (got.last_byte !== want.last_byte) begin
            o_errors++;
            $display("%0t: last_byte expected %0d actual %0d", $time, want.last_byte,
                     got.last_byte);
        end
        if (got.reading_quantity !== want.reading_quantity) begin
            o_errors++;
            $display("%0t: reading_quantity expected %0d actual %0d", $time,
                     want.reading_quantity, got.reading_quantity);
        end
        if (got.reading_value !== want.reading_value) begin
            o_errors++;
            $display("%0t: reading_value expected %h actual %h", $time,
                     want.reading_value, got.reading_value);
        end
        if (got.crc_ok !== want.crc_ok) begin
            o_errors++;
            $display("%0t: crc_ok expected %0d actual %0d", $time, want.crc_ok, got.crc_ok);
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            addr_q = 8'd1;
            fcode_q = 8'd4;
            quantity_q = 3'd0;
            byte_cnt = 4'd0;
            run_crc = 16'hFFFF;
            for (int k = 0; k < 4; k++) value_bytes[k] = 8'd0;
            crc_lo_q = 8'd0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mrfm_pkg::REG_SLAVE_ADDRESS) addr_q = i_cfg_data;
                else if (i_cfg_index == mrfm_pkg::REG_FUNCTION_CODE) fcode_q = i_cfg_data;
            end
            if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) check_result();
            if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
                predict(in_mon.func, in_mon.quantity, in_mon.rx_byte);
        end
    end
endmodule
`default_nettype wire

/* verif/modbus_rtu_float_register_master_tb.sv */
`default_nettype none
module modbus_rtu_float_register_master_tb;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 470;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    int         errors;
    int         waiting;
    int         cycles = 0;
    int         items_sent;
    int         frames_sent;
    int         requests_sent;
    bit         no_gaps;
    bit         no_stalls;
    logic [7:0] slave_addr_now;
    logic [7:0] fcode_now;

    mrfm_in_if  in_ch ();
    mrfm_out_if out_ch ();

    modbus_rtu_float_register_master uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_in(in_ch.sink), .m_out(out_ch.source)
    );

    mrfm_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_mon(in_ch), .out_mon(out_ch), .o_errors(errors), .o_waiting(waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("modbus_rtu_float_register_master_tb NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver back-pressure: short stalls mostly, occasional long ones; none while no_stalls is set.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (no_stalls) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [15:0] frame_crc(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        return r;
    endfunction

    task automatic send(input logic f, input logic [2:0] q, input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.quantity <= q;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        if (f == mrfm_pkg::FUNC_RX || (q >= 3'd1 && q <= 3'd5)) items_sent++;
        if (f == mrfm_pkg::FUNC_REQ && q >= 3'd1 && q <= 3'd5) requests_sent++;
    endtask

    task automatic send_response(input logic [31:0] fbits, input bit corrupt);
        logic [7:0]  bytes [9];
        logic [15:0] c;
        bytes[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : slave_addr_now;
        bytes[1] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : fcode_now;
        bytes[2] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h04;
        {bytes[3], bytes[4], bytes[5], bytes[6]} = fbits;
        c = 16'hFFFF;
        for (int k = 0; k < 7; k++) c = frame_crc(c, bytes[k]);
        bytes[7] = c[7:0];
        bytes[8] = c[15:8];
        if (corrupt) bytes[7 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        for (int k = 0; k < 9; k++) send(mrfm_pkg::FUNC_RX, 3'd0, bytes[k]);
        frames_sent++;
    endtask

    function automatic logic [31:0] random_float();
        int          r;
        logic [31:0] f;
        f = $urandom;
        r = $urandom_range(0, 99);
        if (r < 60) f[30:23] = 8'($urandom_range(127, 158));
        else if (r < 70) f[30:23] = 8'($urandom_range(159, 170));
        else if (r < 80) f[30:23] = 8'($urandom_range(0, 126));
        else if (r < 88) f[30:23] = 8'hFF;
        if ($urandom_range(0, 3) != 0 && r < 60) f[31] = 1'b0;
        if (r >= 80 && r < 84) f[22:0] = 23'd0;
        return f;
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        // bytes that produce no result may still be in flight
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [7:0] addr, input logic [7:0] fc);
        i_cfg_we <= 1'b1;
        i_cfg_index <= mrfm_pkg::REG_SLAVE_ADDRESS;
        i_cfg_data <= addr;
        @(posedge i_clk);
        i_cfg_index <= mrfm_pkg::REG_FUNCTION_CODE;
        i_cfg_data <= fc;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        slave_addr_now = addr;
        fcode_now = fc;
    endtask

    task automatic random_traffic(input int upto);
        int r;
        while (items_sent < upto) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                if ($urandom_range(0, 9) != 0)
                    send(mrfm_pkg::FUNC_REQ, 3'($urandom_range(1, 5)), 8'($urandom));
                send_response(random_float(), $urandom_range(0, 9) == 0);
            end else if (r < 82) begin
                send(mrfm_pkg::FUNC_REQ, 3'($urandom_range(1, 5)), 8'($urandom));
            end else if (r < 94) begin
                send(mrfm_pkg::FUNC_RX, 3'($urandom), 8'($urandom));
            end else begin
                send(mrfm_pkg::FUNC_REQ,
                     ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(6, 7)),
                     8'($urandom));
            end
        end
    endtask

    initial begin
        items_sent = 0;
        frames_sent = 0;
        requests_sent = 0;
        no_gaps = 1'b0;
        no_stalls = 1'b0;
        slave_addr_now = 8'd1;
        fcode_now = 8'd4;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= 8'd0;
        i_cfg_data <= 8'd0;
        in_ch.valid <= 1'b0;
        in_ch.func <= 1'b0;
        in_ch.quantity <= 3'd0;
        in_ch.rx_byte <= 8'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reply with no request pending, then every quantity and the bad ones
        send_response(32'h3F80_0000, 1'b0);
        for (int q = 0; q < 8; q++) send(mrfm_pkg::FUNC_REQ, 3'(q), 8'hFF);
        send_response(32'h8000_0000, 1'b0);
        send(mrfm_pkg::FUNC_REQ, 3'd1, 8'h00);
        send_response(32'hFF80_0000, 1'b0);
        send_response(32'h7F80_0000, 1'b0);
        send_response(32'hFFC0_0001, 1'b0);
        send_response(32'h4F80_0000, 1'b0);
        send_response(32'h4F7F_FFFF, 1'b0);
        send_response(32'h3F00_0000, 1'b0);
        send_response(32'h4B00_0001, 1'b1);
        drain();

        no_gaps = 1'b1;
        no_stalls = 1'b1;
        set_registers(8'h00, 8'h00);
        random_traffic(130);
        drain();
        no_gaps = 1'b0;
        no_stalls = 1'b0;
        set_registers(8'hFF, 8'hFF);
        random_traffic(260);
        drain();
        set_registers(8'($urandom), 8'($urandom));
        random_traffic(370);
        drain();
        set_registers(8'h01, 8'h04);
        random_traffic(ITEM_TARGET);
        drain();

        $display("covered %0d items: %0d requests, %0d response frames", items_sent,
                 requests_sent, frames_sent);
        $display("register settings: reset, all zeros, all ones, random; %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("modbus_rtu_float_register_master_tb OK");
        end else begin
            $display("modbus_rtu_float_register_master_tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* modbus_rtu_float_register_master.f */
hdl/mrfm_pkg.sv
hdl/mrfm_if.sv
hdl/mrfm_front.sv
hdl/mrfm_queue.sv
hdl/mrfm_back.sv
hdl/modbus_rtu_float_register_master.sv
verif/mrfm_checker.sv
verif/modbus_rtu_float_register_master_tb.sv
